FILE: hw/rtl/plb_pkg.sv
package plb_pkg;

	// default sizes
	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// fixed field widths
	localparam int CNT_W  = 7;
	localparam int POS_W  = 7;
	localparam int VAL_W  = 32;
	localparam int ELEM_W = 32;

	// request codes
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_UPDATE = 2'd2,
		ACT_READ   = 2'd3
	} act_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} st_t;

	// cell array operations
	typedef enum logic [2:0] {
		OP_NONE,
		OP_INS,
		OP_DEL,
		OP_UPD,
		OP_ROT
	} op_t;

	// controller to datapath command
	typedef struct packed {
		op_t op;
		logic load;
		st_t status;
		logic last;
	} cmd_t;

endpackage

FILE: hw/rtl/plb_ctrl.sv
module plb_ctrl #(
	parameter int DEPTH = plb_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [1:0]               action,
	input  logic [plb_pkg::POS_W-1:0] position,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	input  logic [plb_pkg::CNT_W-1:0] cnt,
	output plb_pkg::cmd_t            cmd
);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	localparam logic [plb_pkg::CNT_W-1:0] FULL_CNT = plb_pkg::CNT_W'(DEPTH);
	localparam logic [plb_pkg::CNT_W-1:0] ONE_CNT  = plb_pkg::CNT_W'(1);

	state_t state_q;
	logic rsp_valid_q;
	logic [plb_pkg::CNT_W-1:0] rem_q;
	logic load_ok;
	logic accept;
	plb_pkg::act_t act;

	assign act = plb_pkg::act_t'(action);

	// result register is free or its transfer happens now
	assign load_ok   = !rsp_valid_q || !rsp_stall;
	assign req_stall = !(state_q == S_IDLE && load_ok);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;

	// decode request checks into a command
	always_comb begin
		cmd.op     = plb_pkg::OP_NONE;
		cmd.load   = 1'b0;
		cmd.status = plb_pkg::ST_OK;
		cmd.last   = 1'b1;
		if (state_q == S_READ) begin
			if (load_ok) begin
				cmd.op   = plb_pkg::OP_ROT;
				cmd.load = 1'b1;
				cmd.last = (rem_q == ONE_CNT);
			end
		end else if (accept) begin
			cmd.load = 1'b1;
			if (act == plb_pkg::ACT_INSERT) begin
				if (cnt >= FULL_CNT) begin
					cmd.status = plb_pkg::ST_FULL;
				end else if (position > cnt) begin
					cmd.status = plb_pkg::ST_BADPOS;
				end else begin
					cmd.op = plb_pkg::OP_INS;
				end
			end else if (cnt == '0) begin
				cmd.status = plb_pkg::ST_EMPTY;
			end else if (act == plb_pkg::ACT_READ) begin
				cmd.op   = plb_pkg::OP_ROT;
				cmd.last = (cnt == ONE_CNT);
			end else if (position >= cnt) begin
				cmd.status = plb_pkg::ST_BADPOS;
			end else if (act == plb_pkg::ACT_DELETE) begin
				cmd.op = plb_pkg::OP_DEL;
			end else begin
				cmd.op = plb_pkg::OP_UPD;
			end
		end
	end

	// state, result valid and remaining read count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			rem_q       <= '0;
		end else begin
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.op == plb_pkg::OP_ROT && !cmd.last) begin
						state_q <= S_READ;
						rem_q   <= cnt - ONE_CNT;
					end
				end
				S_READ: begin
					if (cmd.load) begin
						rem_q <= rem_q - ONE_CNT;
						if (cmd.last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/plb_cells.sv
module plb_cells #(
	parameter int DEPTH      = plb_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = plb_pkg::DATA_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  plb_pkg::cmd_t                    cmd,
	input  logic [plb_pkg::POS_W-1:0]        position,
	input  logic signed [plb_pkg::VAL_W-1:0] value,
	output logic [plb_pkg::CNT_W-1:0]        cnt,
	output logic [1:0]                       status,
	output logic signed [plb_pkg::ELEM_W-1:0] element,
	output logic                             last,
	output logic [plb_pkg::CNT_W-1:0]        count
);

	localparam logic [plb_pkg::CNT_W-1:0] ONE_CNT = plb_pkg::CNT_W'(1);

	logic [DATA_WIDTH-1:0] cell_q [DEPTH];
	logic [DATA_WIDTH-1:0] cell_d [DEPTH];
	logic [DATA_WIDTH-1:0] word_w;
	logic [plb_pkg::ELEM_W-1:0] head_w;
	logic [plb_pkg::CNT_W-1:0] cnt_q;
	logic [plb_pkg::CNT_W-1:0] cnt_d;
	logic [1:0] status_q;
	logic [plb_pkg::ELEM_W-1:0] element_q;
	logic last_q;
	logic [plb_pkg::CNT_W-1:0] count_q;

	// fit incoming value to the stored word
	if (DATA_WIDTH <= plb_pkg::VAL_W) begin : g_word_narrow
		assign word_w = value[DATA_WIDTH-1:0];
	end else begin : g_word_wide
		assign word_w = {{(DATA_WIDTH - plb_pkg::VAL_W){value[plb_pkg::VAL_W-1]}}, value};
	end

	// head cell as a result element
	if (DATA_WIDTH >= plb_pkg::ELEM_W) begin : g_head_wide
		assign head_w = cell_q[0][plb_pkg::ELEM_W-1:0];
	end else begin : g_head_narrow
		assign head_w = {{(plb_pkg::ELEM_W - DATA_WIDTH){1'b0}}, cell_q[0]};
	end

	// next value of each cell from its neighbors
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_d[i] = cell_q[i];
			case (cmd.op)
				plb_pkg::OP_INS: begin
					if (plb_pkg::POS_W'(i) == position) begin
						cell_d[i] = word_w;
					end else if (plb_pkg::POS_W'(i) > position) begin
						cell_d[i] = cell_q[(i > 0) ? i - 1 : i];
					end
				end
				plb_pkg::OP_DEL: begin
					if (plb_pkg::POS_W'(i) >= position) begin
						cell_d[i] = cell_q[(i < DEPTH - 1) ? i + 1 : i];
					end
				end
				plb_pkg::OP_UPD: begin
					if (plb_pkg::POS_W'(i) == position) begin
						cell_d[i] = word_w;
					end
				end
				plb_pkg::OP_ROT: begin
					// rotate live entries down, head wraps to the top
					if (plb_pkg::CNT_W'(i + 1) == cnt_q) begin
						cell_d[i] = cell_q[0];
					end else if (plb_pkg::CNT_W'(i + 1) < cnt_q) begin
						cell_d[i] = cell_q[(i < DEPTH - 1) ? i + 1 : i];
					end
				end
				default: begin
					cell_d[i] = cell_q[i];
				end
			endcase
		end
	end

	// entry count after the operation
	always_comb begin
		case (cmd.op)
			plb_pkg::OP_INS: cnt_d = cnt_q + ONE_CNT;
			plb_pkg::OP_DEL: cnt_d = cnt_q - ONE_CNT;
			default:         cnt_d = cnt_q;
		endcase
	end

	// cell storage
	always_ff @(posedge clk) begin
		cell_q <= cell_d;
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q  <= cmd.status;
			last_q    <= cmd.last;
			count_q   <= cnt_d;
			element_q <= (cmd.op == plb_pkg::OP_ROT) ? head_w : '0;
		end
	end

	assign cnt     = cnt_q;
	assign status  = status_q;
	assign element = element_q;
	assign last    = last_q;
	assign count   = count_q;

endmodule

FILE: hw/rtl/positional_list_buffer_unit.sv
// channel   | handshake            | fields
// ----------+----------------------+--------------------------------------
// request   | req_valid, req_stall | action, position, value
// response  | rsp_valid, rsp_stall | status, element, last, count
//
// insert, delete, update and rejected requests each give a single result.
// a read gives one result per stored entry, one per cycle while rsp_stall is
// low, and holds the request side while the cell array rotates through once.
// reset clears the entry count and the result valid; cells are not cleared.
// outside a read, a request is taken when the result register is empty or
// transfers in the same cycle; rsp_stall holds results and pauses a read.
module positional_list_buffer_unit #(
	parameter int DEPTH      = plb_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = plb_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [1:0]                        action,
	input  logic [plb_pkg::POS_W-1:0]         position,
	input  logic signed [plb_pkg::VAL_W-1:0]  value,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [1:0]                        status,
	output logic signed [plb_pkg::ELEM_W-1:0] element,
	output logic                              last,
	output logic [plb_pkg::CNT_W-1:0]         count
);

	plb_pkg::cmd_t cmd;
	logic [plb_pkg::CNT_W-1:0] cnt;

	// request checks and read sequencing
	plb_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.action    (action),
		.position  (position),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cnt       (cnt),
		.cmd       (cmd)
	);

	// entry cells, count and result register
	plb_cells #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_cells (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.position (position),
		.value    (value),
		.cnt      (cnt),
		.status   (status),
		.element  (element),
		.last     (last),
		.count    (count)
	);

`ifndef SYNTH
	// the entry count never passes the capacity
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt <= plb_pkg::CNT_W'(DEPTH))
		else $error("entry count above capacity");

	// a pending non-final result means a read is running, so requests wait
	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |-> req_stall)
		else $error("request taken during a read");

	// the count only moves after an accepted request
	a_cnt_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt) |-> $past(req_valid && !req_stall))
		else $error("entry count changed without a request");

	// error results are single and carry no element
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != plb_pkg::ST_OK |-> last && element == '0)
		else $error("malformed error result");
`endif

endmodule
